@@ hdl/gh_pkg.sv @@
// ----------------------------------------------------------------------------
// gh_pkg
// Shared types and constants of the GHASH authenticator.
// ----------------------------------------------------------------------------
`default_nettype none

package gh_pkg;

  localparam int BLOCK_BITS  = 128;
  localparam int BLOCK_BYTES = 16;
  localparam int WORD_BITS   = 64;
  localparam int NBYTES_W    = 5;
  localparam int ACTION_W    = 2;
  localparam int CFG_INDEX_W = 1;

  // x^128 = x^7 + x^2 + x + 1, taps in the unreflected domain
  localparam logic [7:0] REDUCE_TAPS = 8'h87;

  localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 1'b1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_AAD    = 2'd0,
    ACT_TEXT   = 2'd1,
    ACT_FINISH = 2'd2
  } action_t;

  // work handed from the input stage to the hash stage
  typedef struct packed {
    logic                  valid;
    logic                  finish;
    logic                  length_error;
    logic [BLOCK_BITS-1:0] block;
  } stage_t;

endpackage

`default_nettype wire

@@ hdl/gh_in_if.sv @@
// ----------------------------------------------------------------------------
// gh_in_if
// Input channel: one block word or a finish request per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface gh_in_if;
  logic                             valid;
  logic                             ready;
  logic [gh_pkg::ACTION_W-1:0]      action;
  logic [gh_pkg::WORD_BITS-1:0]     data_high;
  logic [gh_pkg::WORD_BITS-1:0]     data_low;
  logic [gh_pkg::NBYTES_W-1:0]      valid_bytes;

  modport source (output valid, action, data_high, data_low, valid_bytes, input ready);
  modport sink   (input valid, action, data_high, data_low, valid_bytes, output ready);
endinterface

`default_nettype wire

@@ hdl/gh_out_if.sv @@
// ----------------------------------------------------------------------------
// gh_out_if
// Result channel: one tag word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface gh_out_if;
  logic                         valid;
  logic                         ready;
  logic [gh_pkg::WORD_BITS-1:0] tag_high;
  logic [gh_pkg::WORD_BITS-1:0] tag_low;
  logic                         length_error;

  modport source (output valid, tag_high, tag_low, length_error, input ready);
  modport sink   (input valid, tag_high, tag_low, length_error, output ready);
endinterface

`default_nettype wire

@@ hdl/gh_gfmul.sv @@
// ----------------------------------------------------------------------------
// gh_gfmul
// Full-width GF(2^128) multiply in GCM bit order: carry-less product
// followed by a two-fold reduction.
// ----------------------------------------------------------------------------
`default_nettype none

module gh_gfmul (
  input  wire logic [gh_pkg::BLOCK_BITS-1:0] a,
  input  wire logic [gh_pkg::BLOCK_BITS-1:0] b,
  output logic      [gh_pkg::BLOCK_BITS-1:0] p
);

  localparam int N = gh_pkg::BLOCK_BITS;

  logic [N-1:0]   ar;
  logic [N-1:0]   br;
  logic [2*N-2:0] prod;
  logic [N-2:0]   hi;
  logic [N+5:0]   fold1;
  logic [13:0]    fold2;
  logic [N-1:0]   low;

  // gcm bit 0 is the msb; reverse so index i is the coefficient of x^i
  always_comb begin
    for (int i = 0; i < N; i++) begin
      ar[i] = a[N-1-i];
      br[i] = b[N-1-i];
    end
  end

  always_comb begin
    prod = '0;
    for (int i = 0; i < N; i++) begin
      if (ar[i]) begin
        prod = prod ^ ({{(N-1){1'b0}}, br} << i);
      end
    end
  end

  always_comb begin
    hi    = prod[2*N-2:N];
    fold1 = '0;
    for (int k = 0; k < 8; k++) begin
      if (gh_pkg::REDUCE_TAPS[k]) begin
        fold1 = fold1 ^ ({7'b0, hi} << k);
      end
    end
    fold2 = '0;
    for (int k = 0; k < 8; k++) begin
      if (gh_pkg::REDUCE_TAPS[k]) begin
        fold2 = fold2 ^ ({8'b0, fold1[N+5:N]} << k);
      end
    end
    low = prod[N-1:0] ^ fold1[N-1:0] ^ {{(N-14){1'b0}}, fold2};
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      p[i] = low[N-1-i];
    end
  end

endmodule

`default_nettype wire

@@ hdl/gh_front.sv @@
// ----------------------------------------------------------------------------
// gh_front
// Input stage: byte masking, AAD and text byte counters with saturation,
// length block on finish, and the register feeding the hash stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gh_front #(
  parameter int LEN_COUNT_WIDTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              load,
  input  wire logic                              take,
  input  wire logic [gh_pkg::ACTION_W-1:0]       action,
  input  wire logic [gh_pkg::WORD_BITS-1:0]      data_high,
  input  wire logic [gh_pkg::WORD_BITS-1:0]      data_low,
  input  wire logic [gh_pkg::NBYTES_W-1:0]       valid_bytes,
  output gh_pkg::stage_t                         stage_r
);

  localparam int CW = LEN_COUNT_WIDTH;
  localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

  logic [CW-1:0] aad_cnt_r, aad_cnt_nxt;
  logic [CW-1:0] text_cnt_r, text_cnt_nxt;
  logic          ovf_r, ovf_nxt;
  gh_pkg::stage_t stage_nxt;

  logic [gh_pkg::NBYTES_W-1:0]   nbytes;
  logic [gh_pkg::BLOCK_BITS-1:0] masked;
  logic [gh_pkg::BLOCK_BITS-1:0] raw;
  logic [CW:0]                   aad_sum;
  logic [CW:0]                   text_sum;
  logic [gh_pkg::WORD_BITS-1:0]  aad_len_bits;
  logic [gh_pkg::WORD_BITS-1:0]  text_bits;

  always_comb begin
    nbytes = (valid_bytes > gh_pkg::NBYTES_W'(gh_pkg::BLOCK_BYTES)) ?
             gh_pkg::NBYTES_W'(gh_pkg::BLOCK_BYTES) : valid_bytes;
    raw    = {data_high, data_low};
    for (int j = 0; j < gh_pkg::BLOCK_BYTES; j++) begin
      masked[gh_pkg::BLOCK_BITS-1-8*j -: 8] =
        (gh_pkg::NBYTES_W'(j) < nbytes) ? raw[gh_pkg::BLOCK_BITS-1-8*j -: 8] : 8'h00;
    end
  end

  assign aad_sum      = {1'b0, aad_cnt_r}  + {{(CW+1-gh_pkg::NBYTES_W){1'b0}}, nbytes};
  assign text_sum     = {1'b0, text_cnt_r} + {{(CW+1-gh_pkg::NBYTES_W){1'b0}}, nbytes};
  assign aad_len_bits = {{(gh_pkg::WORD_BITS-CW-3){1'b0}}, aad_cnt_r, 3'b000};
  assign text_bits    = {{(gh_pkg::WORD_BITS-CW-3){1'b0}}, text_cnt_r, 3'b000};

  always_comb begin
    aad_cnt_nxt            = aad_cnt_r;
    text_cnt_nxt           = text_cnt_r;
    ovf_nxt                = ovf_r;
    stage_nxt              = stage_r;
    if (load) begin
      stage_nxt.valid        = 1'b0;
      stage_nxt.finish       = 1'b0;
      stage_nxt.length_error = ovf_r;
      stage_nxt.block        = masked;
      if (take) begin
        case (gh_pkg::action_t'(action))
          gh_pkg::ACT_AAD: begin
            if (nbytes != '0) begin
              stage_nxt.valid = 1'b1;
              if (aad_sum > {1'b0, COUNT_MAX}) begin
                aad_cnt_nxt = COUNT_MAX;
                ovf_nxt     = 1'b1;
              end else begin
                aad_cnt_nxt = aad_sum[CW-1:0];
              end
            end
          end
          gh_pkg::ACT_TEXT: begin
            if (nbytes != '0) begin
              stage_nxt.valid = 1'b1;
              if (text_sum > {1'b0, COUNT_MAX}) begin
                text_cnt_nxt = COUNT_MAX;
                ovf_nxt      = 1'b1;
              end else begin
                text_cnt_nxt = text_sum[CW-1:0];
              end
            end
          end
          gh_pkg::ACT_FINISH: begin
            stage_nxt.valid  = 1'b1;
            stage_nxt.finish = 1'b1;
            stage_nxt.block  = {aad_len_bits, text_bits};
            aad_cnt_nxt      = '0;
            text_cnt_nxt     = '0;
            ovf_nxt          = 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aad_cnt_r  <= '0;
      text_cnt_r <= '0;
      ovf_r      <= 1'b0;
      stage_r    <= '0;
    end else begin
      aad_cnt_r  <= aad_cnt_nxt;
      text_cnt_r <= text_cnt_nxt;
      ovf_r      <= ovf_nxt;
      stage_r    <= stage_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ghash_authenticator.sv @@
// ----------------------------------------------------------------------------
// ghash_authenticator
// GCM GHASH over 16-byte blocks with a configurable hash key.
// ----------------------------------------------------------------------------
// One item is accepted every cycle unless input is held off. On its way into
// the input register an item is masked to its valid bytes and counted, or a
// finish becomes the length block. Then the running hash is XORed with that
// block and multiplied by the key; the product goes to the hash register, or on
// a finish to the tag register as the hash clears. The combinational multiply
// and reduce through the hash register set the rate of one block per cycle. A
// finish's tag is registered as the finish leaves the input register. Input is
// held off only while a finish sits there and an earlier tag is not yet taken.
// The user must write key registers only while idle; the block does not check.
`default_nettype none

module ghash_authenticator #(
  parameter int LEN_COUNT_WIDTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  gh_in_if.sink                                  in_ch,
  gh_out_if.source                               out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [gh_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [gh_pkg::WORD_BITS-1:0]      cfg_wdata
);

  gh_pkg::stage_t stage_r;

  logic [gh_pkg::WORD_BITS-1:0]  key_high_r, key_low_r;
  logic [gh_pkg::BLOCK_BITS-1:0] hash_r;
  logic [gh_pkg::BLOCK_BITS-1:0] product;
  logic [gh_pkg::BLOCK_BITS-1:0] tag_r;
  logic                          err_r;
  logic                          out_valid_r;
  logic                          stage_go;
  logic                          consume;
  logic                          in_ready;

  // a finish may only move on once the result register is free
  assign stage_go = !(stage_r.finish && out_valid_r && !out_ch.ready);
  assign in_ready = !stage_r.valid || stage_go;
  assign consume  = stage_r.valid && stage_go;

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.tag_high     = tag_r[gh_pkg::BLOCK_BITS-1:gh_pkg::WORD_BITS];
  assign out_ch.tag_low      = tag_r[gh_pkg::WORD_BITS-1:0];
  assign out_ch.length_error = err_r;

  gh_front #(
    .LEN_COUNT_WIDTH (LEN_COUNT_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (in_ready),
    .take        (in_ch.valid && in_ready),
    .action      (in_ch.action),
    .data_high   (in_ch.data_high),
    .data_low    (in_ch.data_low),
    .valid_bytes (in_ch.valid_bytes),
    .stage_r     (stage_r)
  );

  gh_gfmul u_gfmul (
    .a (hash_r ^ stage_r.block),
    .b ({key_high_r, key_low_r}),
    .p (product)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gh_pkg::REG_KEY_HIGH: key_high_r <= cfg_wdata;
        gh_pkg::REG_KEY_LOW:  key_low_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (out_valid_r && !out_ch.ready) || (consume && stage_r.finish);
      if (consume) begin
        hash_r <= stage_r.finish ? '0 : product;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (consume && stage_r.finish) begin
      tag_r <= product;
      err_r <= stage_r.length_error;
    end
  end

endmodule

`default_nettype wire
